>>> sv/hpq_pkg.sv
// hpq_pkg: operation and status codes for the heap priority queue
// no dependencies; used by the engine, the checker and the testbench
package hpq_pkg;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
endpackage

>>> sv/hpq_ram.sv
// hpq_ram: generic single write, single read ram with registered read data
// no dependencies
module hpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> sv/hpq_front.sv
// hpq_front: accepts items and holds them in a two-entry queue for the engine
// no package dependencies
module hpq_front #(
	parameter int KEY_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [KEY_WIDTH-1:0] key,
	output logic                 cmd_valid,
	output logic                 cmd_op,
	output logic [KEY_WIDTH-1:0] cmd_key,
	input  logic                 cmd_take
);
	logic                 op_q  [2];
	logic [KEY_WIDTH-1:0] key_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 push;

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd_op    = op_q[rd_ptr_q];
	assign cmd_key   = key_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]  <= op;
			key_q[wr_ptr_q] <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !cmd_take) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && cmd_take) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end
endmodule

>>> sv/hpq_engine.sv
// hpq_engine: sift-up / sift-down sequencer over the heap ram
// depends on hpq_pkg and hpq_ram
module hpq_engine #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              min_first,
	input  logic                              cmd_valid,
	input  logic                              cmd_op,
	input  logic [KEY_WIDTH-1:0]              cmd_key,
	output logic                              cmd_take,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [KEY_WIDTH-1:0]              popped_key,
	output logic [KEY_WIDTH-1:0]              top_key,
	output logic                              top_valid,
	output logic [$clog2(CAPACITY+1)-1:0]     count
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UP_RD   = 4'd1;
	localparam logic [3:0] S_UP_CMP  = 4'd2;
	localparam logic [3:0] S_LAST_RD = 4'd3;
	localparam logic [3:0] S_LAST_WT = 4'd4;
	localparam logic [3:0] S_DN_RDL  = 4'd5;
	localparam logic [3:0] S_DN_RDR  = 4'd6;
	localparam logic [3:0] S_DN_CMP  = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;

	logic [3:0]           state_q;
	logic [AW-1:0]        pos_q;
	logic [CW-1:0]        cnt_q;
	logic [KEY_WIDTH-1:0] cur_q;
	logic [KEY_WIDTH-1:0] lv_q;
	logic [KEY_WIDTH-1:0] top_q;
	logic [KEY_WIDTH-1:0] popped_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [KEY_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [KEY_WIDTH-1:0] ram_rdata;

	logic [AW-1:0]        parent;
	logic [AW+1:0]        lft;
	logic [AW+1:0]        rgt;
	logic [AW+1:0]        cnt_ext;
	logic                 up_win;
	logic                 l_win;
	logic                 r_win;
	logic [KEY_WIDTH-1:0] bestv;

	function automatic logic ranks(input logic [KEY_WIDTH-1:0] a,
			input logic [KEY_WIDTH-1:0] b, input logic mf);
		ranks = mf ? (a < b) : (a > b);
	endfunction

	hpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign parent   = (pos_q - AW'(1)) >> 1;
	assign lft      = {1'b0, pos_q, 1'b1};
	assign rgt      = lft + (AW+2)'(1);
	assign cnt_ext  = (AW+2)'(cnt_q);
	assign up_win   = ranks(cur_q, ram_rdata, min_first);
	assign l_win    = ranks(lv_q, cur_q, min_first);
	assign bestv    = l_win ? lv_q : cur_q;
	assign r_win    = (rgt < cnt_ext) && ranks(ram_rdata, bestv, min_first);
	assign cmd_take = (state_q == S_IDLE) && cmd_valid;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = cur_q;
		ram_raddr = parent;
		case (state_q)
			S_UP_CMP: begin
				ram_we    = up_win;
				ram_wdata = ram_rdata;
			end
			S_LAST_RD: ram_raddr = cnt_q[AW-1:0];
			S_DN_RDL:  ram_raddr = lft[AW-1:0];
			S_DN_RDR:  ram_raddr = rgt[AW-1:0];
			S_DN_CMP: begin
				ram_we    = r_win || l_win;
				ram_wdata = r_win ? ram_rdata : lv_q;
			end
			S_FIN:   ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LAST_WT: cur_q <= ram_rdata;
			S_DN_RDR:  lv_q  <= ram_rdata;
			S_IDLE: begin
				if (cmd_valid) begin
					cur_q    <= cmd_key;
					popped_q <= (cmd_op == hpq_pkg::OP_POP) ? top_q : '0;
				end
			end
			default: lv_q <= lv_q;
		endcase
		if (ram_we && ram_waddr == '0) begin
			top_q <= ram_wdata;
		end
		popped_key <= popped_q;
		top_key    <= top_q;
		if (state_q == S_IDLE) begin
			popped_key <= '0;
			top_key    <= (cnt_q == '0) ? '0 : top_q;
			if (cmd_op == hpq_pkg::OP_POP && cnt_q == CW'(1)) begin
				popped_key <= top_q;
				top_key    <= '0;
			end
		end else if (state_q == S_FIN && pos_q == '0) begin
			top_key <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			cnt_q     <= '0;
			done      <= 1'b0;
			status    <= hpq_pkg::ST_DONE;
			top_valid <= 1'b0;
			count     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd_op == hpq_pkg::OP_INSERT) begin
							if (cnt_q == CAP_C) begin
								done      <= 1'b1;
								status    <= hpq_pkg::ST_FULL;
								top_valid <= 1'b1;
								count     <= cnt_q;
							end else begin
								pos_q   <= cnt_q[AW-1:0];
								cnt_q   <= cnt_q + CW'(1);
								state_q <= (cnt_q == '0) ? S_FIN : S_UP_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								done      <= 1'b1;
								status    <= hpq_pkg::ST_EMPTY;
								top_valid <= 1'b0;
								count     <= cnt_q;
							end else if (cnt_q == CW'(1)) begin
								cnt_q     <= '0;
								done      <= 1'b1;
								status    <= hpq_pkg::ST_DONE;
								top_valid <= 1'b0;
								count     <= '0;
							end else begin
								cnt_q   <= cnt_q - CW'(1);
								state_q <= S_LAST_RD;
							end
						end
					end
				end
				S_UP_RD: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (up_win) begin
						pos_q   <= parent;
						state_q <= (parent == '0) ? S_FIN : S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LAST_RD: state_q <= S_LAST_WT;
				S_LAST_WT: begin
					pos_q   <= '0;
					state_q <= S_DN_RDL;
				end
				S_DN_RDL: state_q <= (lft >= cnt_ext) ? S_FIN : S_DN_RDR;
				S_DN_RDR: state_q <= S_DN_CMP;
				S_DN_CMP: begin
					if (r_win) begin
						pos_q   <= rgt[AW-1:0];
						state_q <= S_DN_RDL;
					end else if (l_win) begin
						pos_q   <= lft[AW-1:0];
						state_q <= S_DN_RDL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done      <= 1'b1;
					status    <= hpq_pkg::ST_DONE;
					top_valid <= 1'b1;
					count     <= cnt_q;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/binary_max_heap_priority_queue.sv
// channel | handshake           | payload
// input   | start / busy        | op, key
// result  | done (one cycle)    | status, popped_key, top_key, top_valid, count
// config  | cfg_we              | cfg_min_first
// a refused item, or a pop that empties the heap, is answered from idle without the ram;
// an insert reads and compares parents as it climbs, a pop takes the last entry as the
// new root and reads the children of each level as it descends, through the single ram read port
// a two-entry queue takes items while the engine works; busy only when it is full
// reset clears the count; heap contents need no clearing; done is never held off
// top level of the heap priority queue; depends on hpq_front and hpq_engine
module binary_max_heap_priority_queue #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [KEY_WIDTH-1:0]          key,
	input  logic                          cfg_we,
	input  logic                          cfg_min_first,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [KEY_WIDTH-1:0]          popped_key,
	output logic [KEY_WIDTH-1:0]          top_key,
	output logic                          top_valid,
	output logic [$clog2(CAPACITY+1)-1:0] count
);
	logic                 min_first_q;
	logic                 cmd_valid;
	logic                 cmd_op;
	logic [KEY_WIDTH-1:0] cmd_key;
	logic                 cmd_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_first_q <= 1'b0;
		end else if (cfg_we) begin
			min_first_q <= cfg_min_first;
		end
	end

	hpq_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.key       (key),
		.cmd_valid (cmd_valid),
		.cmd_op    (cmd_op),
		.cmd_key   (cmd_key),
		.cmd_take  (cmd_take)
	);

	hpq_engine #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.min_first  (min_first_q),
		.cmd_valid  (cmd_valid),
		.cmd_op     (cmd_op),
		.cmd_key    (cmd_key),
		.cmd_take   (cmd_take),
		.done       (done),
		.status     (status),
		.popped_key (popped_key),
		.top_key    (top_key),
		.top_valid  (top_valid),
		.count      (count)
	);
endmodule

>>> sv/hpq_checker.sv
// hpq_checker: port-level checks on the heap priority queue results
// depends on hpq_pkg; bound to binary_max_heap_priority_queue
module hpq_checker #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          done,
	input logic [1:0]                    status,
	input logic [KEY_WIDTH-1:0]          popped_key,
	input logic [KEY_WIDTH-1:0]          top_key,
	input logic                          top_valid,
	input logic [$clog2(CAPACITY+1)-1:0] count
);
	localparam int CW = $clog2(CAPACITY + 1);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count <= CW'(CAPACITY)) else $error("count above capacity");

	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> top_valid == (count != '0)) else $error("top_valid mismatch");

	a_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !top_valid |-> top_key == '0) else $error("empty top not zero");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != hpq_pkg::ST_DONE |-> popped_key == '0)
		else $error("refused item popped a key");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == hpq_pkg::ST_FULL |-> count == CW'(CAPACITY))
		else $error("full refusal below capacity");
endmodule

bind binary_max_heap_priority_queue hpq_checker #(
	.CAPACITY  (CAPACITY),
	.KEY_WIDTH (KEY_WIDTH)
) u_hpq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.done       (done),
	.status     (status),
	.popped_key (popped_key),
	.top_key    (top_key),
	.top_valid  (top_valid),
	.count      (count)
);

>>> tb/sv/tb_binary_max_heap_priority_queue.sv
// testbench for binary_max_heap_priority_queue: directed table then random inserts and pops,
// each done result checked against a behavioral heap kept in the bench
// depends on hpq_pkg and the binary_max_heap_priority_queue rtl
module tb_binary_max_heap_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 256;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] popped_key;
		logic [31:0] top_key;
		logic        top_valid;
		logic [8:0]  count;
	} heap_result_t;

	typedef struct {
		logic        op;
		logic [31:0] key;
		logic        typed;
		heap_result_t res;
	} stim_row_t;

	logic        clk, arst_n, start, busy, op, cfg_we, cfg_min_first;
	logic [31:0] key;
	logic        done, top_valid;
	logic [1:0]  status;
	logic [31:0] popped_key, top_key;
	logic [8:0]  count;

	binary_max_heap_priority_queue #(.CAPACITY(CAP), .KEY_WIDTH(32)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .key(key),
		.cfg_we(cfg_we), .cfg_min_first(cfg_min_first), .done(done), .status(status),
		.popped_key(popped_key), .top_key(top_key), .top_valid(top_valid), .count(count)
	);

	logic [31:0]  model_heap [CAP];
	int           model_size;
	logic         model_min;
	heap_result_t pending_results [$];
	int           errors, results_seen, fulls, empties;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic bit outranks(logic [31:0] a, logic [31:0] b);
		return model_min ? (a < b) : (a > b);
	endfunction

	function automatic heap_result_t heap_apply(logic o, logic [31:0] k);
		heap_result_t r;
		int p, q, best, l;
		logic [31:0] t;
		r = '0;
		if (o == hpq_pkg::OP_INSERT) begin
			if (model_size >= CAP) begin
				r.status = hpq_pkg::ST_FULL;
			end else begin
				p = model_size;
				model_heap[p] = k;
				model_size++;
				while (p > 0) begin
					q = (p - 1) / 2;
					if (!outranks(model_heap[p], model_heap[q])) break;
					t = model_heap[p]; model_heap[p] = model_heap[q]; model_heap[q] = t;
					p = q;
				end
			end
		end else begin
			if (model_size == 0) begin
				r.status = hpq_pkg::ST_EMPTY;
			end else begin
				r.popped_key = model_heap[0];
				model_size--;
				if (model_size > 0) begin
					model_heap[0] = model_heap[model_size];
					p = 0;
					forever begin
						best = p;
						l = 2 * p + 1;
						if (l < model_size && outranks(model_heap[l], model_heap[best]))
							best = l;
						if (l + 1 < model_size && outranks(model_heap[l + 1], model_heap[best]))
							best = l + 1;
						if (best == p) break;
						t = model_heap[p]; model_heap[p] = model_heap[best]; model_heap[best] = t;
						p = best;
					end
				end
			end
		end
		r.status = r.status;
		r.top_valid = model_size > 0;
		r.top_key = model_size > 0 ? model_heap[0] : 32'd0;
		r.count = model_size[8:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		heap_result_t e;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {30'd0, status}, 32'd0);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status)
					report_mismatch("status", {30'd0, status}, {30'd0, e.status});
				if (popped_key !== e.popped_key) report_mismatch("popped_key", popped_key, e.popped_key);
				if (top_key !== e.top_key) report_mismatch("top_key", top_key, e.top_key);
				if (top_valid !== e.top_valid)
					report_mismatch("top_valid", {31'd0, top_valid}, {31'd0, e.top_valid});
				if (count !== e.count) report_mismatch("count", {23'd0, count}, {23'd0, e.count});
			end
		end
	end

	bit idle_ok;

	task automatic send_item(logic o, logic [31:0] k, bit typed, heap_result_t want);
		heap_result_t r;
		int gap;
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		key <= k;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = heap_apply(o, k);
		if (r.status == hpq_pkg::ST_FULL) fulls++;
		if (r.status == hpq_pkg::ST_EMPTY) empties++;
		if (typed && r !== want) report_mismatch("table row", r.top_key, want.top_key);
		pending_results.push_back(r);
	endtask

	task automatic drain_queue();
		int guard;
		start <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic set_order(logic m);
		cfg_we <= 1'b1;
		cfg_min_first <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_min = m;
	endtask

	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	stim_row_t table_rows [$];

	task automatic add_row(logic o, logic [31:0] k, bit typed, heap_result_t r);
		stim_row_t s;
		s.op = o; s.key = k; s.typed = typed; s.res = r;
		table_rows.push_back(s);
	endtask

	initial begin
		heap_result_t none;
		int n, burst;
		logic o;
		errors = 0; results_seen = 0; fulls = 0; empties = 0;
		model_size = 0; model_min = 1'b0; idle_ok = 1'b0; none = '0;
		arst_n = 1'b0; start = 1'b0; op = 1'b0; key = '0; cfg_we = 1'b0; cfg_min_first = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(hpq_pkg::OP_POP, 32'h1234, 1'b1,
			'{hpq_pkg::ST_EMPTY, 32'd0, 32'd0, 1'b0, 9'd0});
		add_row(hpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
			'{hpq_pkg::ST_DONE, 32'd0, 32'hFFFF_FFFF, 1'b1, 9'd1});
		add_row(hpq_pkg::OP_INSERT, 32'd0, 1'b1,
			'{hpq_pkg::ST_DONE, 32'd0, 32'hFFFF_FFFF, 1'b1, 9'd2});
		add_row(hpq_pkg::OP_INSERT, 32'd5, 1'b0, none);
		add_row(hpq_pkg::OP_INSERT, 32'd5, 1'b0, none);
		add_row(hpq_pkg::OP_INSERT, 32'd9, 1'b0, none);
		add_row(hpq_pkg::OP_POP, 32'd0, 1'b1,
			'{hpq_pkg::ST_DONE, 32'hFFFF_FFFF, 32'd9, 1'b1, 9'd4});
		add_row(hpq_pkg::OP_POP, 32'd0, 1'b0, none);
		add_row(hpq_pkg::OP_POP, 32'd0, 1'b0, none);
		add_row(hpq_pkg::OP_POP, 32'd0, 1'b0, none);
		add_row(hpq_pkg::OP_POP, 32'd0, 1'b1,
			'{hpq_pkg::ST_DONE, 32'd0, 32'd0, 1'b0, 9'd0});
		add_row(hpq_pkg::OP_POP, 32'd0, 1'b1,
			'{hpq_pkg::ST_EMPTY, 32'd0, 32'd0, 1'b0, 9'd0});
		foreach (table_rows[i])
			send_item(table_rows[i].op, table_rows[i].key, table_rows[i].typed, table_rows[i].res);
		drain_queue();

		// fill to capacity in min-first order, refuse one, then flip order while full
		set_order(1'b1);
		idle_ok = 1'b1;
		for (int i = 0; i < CAP; i++) send_item(hpq_pkg::OP_INSERT, rand_key(), 1'b0, none);
		send_item(hpq_pkg::OP_INSERT, 32'hA5A5_A5A5, 1'b0, none);
		drain_queue();
		set_order(1'b0);
		for (int i = 0; i < 20; i++) send_item(hpq_pkg::OP_POP, $urandom, 1'b0, none);
		drain_queue();

		n = 0;
		while (n < 160) begin
			if (n % 55 == 0) begin
				drain_queue();
				set_order(1'($urandom_range(0, 1)));
			end
			if (n > 130) idle_ok = 1'b0;
			burst = $urandom_range(1, 12);
			o = 1'($urandom_range(0, 1));
			for (int j = 0; j < burst && n < 160; j++) begin
				send_item($urandom_range(0, 3) == 0 ? ~o : o, rand_key(), 1'b0, none);
				n++;
			end
		end
		drain_queue();

		$display("ran %0d results, %0d full refusals, %0d empty refusals, both orders",
			results_seen, fulls, empties);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

>>> binary_max_heap_priority_queue.f
sv/hpq_pkg.sv
sv/hpq_ram.sv
sv/hpq_front.sv
sv/hpq_engine.sv
sv/binary_max_heap_priority_queue.sv
sv/hpq_checker.sv
tb/sv/tb_binary_max_heap_priority_queue.sv
